@@ src/plst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants for the positional list store
// Sizes, command codes and the structs that run between the sequencer,
// the entry memory and the top level.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 5;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // width that holds both a position and a count for comparisons
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } cmd_t;

    // memory access request, one read and one write port
    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        data_t wr_data;
    } mem_req_t;

    // finished result word handed to the output register
    typedef struct packed {
        logic             status;
        data_t            read_value;
        logic [LEN_W-1:0] length;
    } res_t;

endpackage

@@ src/positional_list_store_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_core: dense list with insert/delete at a position
// Steps after s accept: read and rejected words go straight to the result,
//   update writes the entry, insert moves k entries and then writes the new
//   one, delete moves k entries; k is at most CAPACITY-1, each move a
//   registered read then a write. s_ready is high only in idle, so a
//   new word waits until the last has gone to the output register.
// Reset: aresetn (sync, active low) empties the list and drops m_valid;
//   entry contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [plst_pkg::CMD_W-1:0]      s_cmd,
    input  logic [plst_pkg::POS_W-1:0]      s_position,
    input  logic signed [plst_pkg::DATA_W-1:0] s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic signed [plst_pkg::DATA_W-1:0] m_read_value,
    output logic [plst_pkg::LEN_W-1:0]      m_length
);
    import plst_pkg::*;

    mem_req_t mem_req;
    data_t    mem_rd_data;
    logic     res_valid;
    logic     res_ready;
    res_t     res;

    // output word register
    logic     m_valid_reg, m_valid_next;
    res_t     out_reg;

    // sequencer: checks the command, then shifts entries one move at a time
    plst_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_position  (s_position),
        .s_value     (s_value),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // entry storage, read data registered
    plst_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // a finished word moves into the output register when it is empty or
    // being drained this cycle, so the sequencer returns to idle while the
    // previous word may still wait for m_ready
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_read_value = out_reg.read_value;
    assign m_length     = out_reg.length;

endmodule

@@ src/plst_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_mem: entry storage
// One write port and one read port with registered read data. The read
// data holds until the next read.
// ----------------------------------------------------------------------------
module plst_mem (
    input  logic               aclk,
    input  plst_pkg::mem_req_t req,
    output plst_pkg::data_t    rd_data
);
    import plst_pkg::*;

    data_t mem [CAPACITY];
    data_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/plst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_ctrl: command sequencer
// Checks each command against the length, then walks the entries one move
// at a time through a shared index step unit (+1 or -1 and a compare).
// ----------------------------------------------------------------------------
module plst_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [plst_pkg::CMD_W-1:0]    s_cmd,
    input  logic [plst_pkg::POS_W-1:0]    s_position,
    input  plst_pkg::data_t               s_value,
    output plst_pkg::mem_req_t            mem_req,
    input  plst_pkg::data_t               mem_rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output plst_pkg::res_t                res
);
    import plst_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_EXEC    = 6'b000010,
        ST_MOVE_RD = 6'b000100,
        ST_MOVE_WR = 6'b001000,
        ST_WRITE   = 6'b010000,
        ST_RESULT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    data_t             word_reg, word_next;
    cnt_t              count_reg, count_next;
    idx_t              idx_reg, idx_next;
    idx_t              limit_reg, limit_next;
    logic              reject_reg, reject_next;

    logic [CMP_W-1:0]  pos_c, cnt_c;
    logic              ins_ok, in_range;
    idx_t              pos_idx, cnt_idx, last_idx;
    cnt_t              cnt_m1;
    idx_t              step_idx;

    // range checks on the latched command
    assign pos_c    = CMP_W'(pos_reg);
    assign cnt_c    = CMP_W'(count_reg);
    assign ins_ok   = (count_reg < CAP_CNT) && (pos_c <= cnt_c);
    assign in_range = pos_c < cnt_c;
    assign pos_idx  = IDX_W'(pos_reg);
    assign cnt_idx  = count_reg[IDX_W-1:0];
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];

    // shared step unit: delete walks up, insert walks down
    assign step_idx = (op_reg == OP_DELETE) ? idx_reg + IDX_W'(1) : idx_reg - IDX_W'(1);

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        limit_next  = limit_reg;
        reject_next = reject_reg;
        mem_req     = '0;
        s_ready     = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = cmd_t'(s_cmd);
                    pos_next   = s_position;
                    word_next  = s_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                reject_next = 1'b1;
                state_next  = ST_RESULT;
                case (op_reg)
                    OP_INSERT: begin
                        if (ins_ok) begin
                            reject_next = 1'b0;
                            idx_next    = cnt_idx;
                            limit_next  = pos_idx;
                            state_next  = (cnt_idx != pos_idx) ? ST_MOVE_RD : ST_WRITE;
                        end
                    end
                    OP_DELETE: begin
                        if (in_range) begin
                            reject_next = 1'b0;
                            idx_next    = pos_idx;
                            limit_next  = last_idx;
                            if (pos_idx != last_idx) begin
                                state_next = ST_MOVE_RD;
                            end else begin
                                count_next = cnt_m1;
                            end
                        end
                    end
                    OP_UPDATE: begin
                        if (in_range) begin
                            reject_next = 1'b0;
                            state_next  = ST_WRITE;
                        end
                    end
                    default: begin
                        if (in_range) begin
                            reject_next     = 1'b0;
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = pos_idx;
                        end
                    end
                endcase
            end
            ST_MOVE_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = step_idx;
                state_next      = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = mem_rd_data;
                idx_next        = step_idx;
                if (step_idx != limit_reg) begin
                    state_next = ST_MOVE_RD;
                end else if (op_reg == OP_DELETE) begin
                    count_next = cnt_m1;
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_idx;
                mem_req.wr_data = word_reg;
                if (op_reg == OP_INSERT) begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.status     = reject_reg;
    assign res.read_value = (op_reg == OP_READ && !reject_reg) ? mem_rd_data : '0;
    assign res.length     = LEN_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        word_reg   <= word_next;
        idx_reg    <= idx_next;
        limit_reg  <= limit_next;
        reject_reg <= reject_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("list length above capacity");

    a_wr_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> CMP_W'(mem_req.wr_addr) <= CMP_W'(count_reg))
        else $error("write beyond end of list");

    a_rd_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.rd_en |-> CMP_W'(mem_req.rd_addr) < CMP_W'(count_reg))
        else $error("read of an entry outside the list");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg)) |->
            ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_MOVE_WR ||
             $past(state_reg) == ST_WRITE))
        else $error("length changed outside a commit step");

endmodule
